// ----- rtl/core/mersenne_twister_generator_defines.svh -----
// assertion macros shared by the generator rtl
// expects clk and rst_n in the scope of each use

`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MTG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtg assertion failed");

// next-cycle implication, checked out of reset
`define MTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtg assertion failed");

`endif

// ----- rtl/core/mtg_pkg.sv -----
// types and constants of the mt19937 generator
// used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int STATE_WORDS = 624;
    localparam int SHIFT_DIST  = 397;
    localparam int POS_W       = $clog2(STATE_WORDS);
    localparam int WORD_W      = 32;

    localparam logic [WORD_W-1:0] SEED_MULT  = 32'h6C07_8965;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

    // request codes
    localparam logic REQ_DRAW   = 1'b0;
    localparam logic REQ_RESEED = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_seed;     // write word 0, restart fill and draw position
        logic fill_step;     // write one word of the seed recurrence
        logic read_pair;     // read words at pos and pos+1
        logic read_far;      // read word at pos+SHIFT_DIST
        logic capture_pair;  // register the mixed upper/lower word
        logic commit;        // write twisted word, load result, advance pos
        logic load_zero;     // load a zero result
    } mtg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_done;     // current fill step writes the last word
    } mtg_sts_t;

endpackage

// ----- rtl/core/mtg_if.sv -----
// request and response channel interfaces of the generator
// depends on mtg_pkg
`timescale 1ns / 1ps

interface mtg_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [mtg_pkg::WORD_W-1:0] seed_value;

    modport source (output valid, output req_type, output seed_value, input ready);
    modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [mtg_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ----- rtl/core/mtg_datapath.sv -----
// datapath: state memory, seed recurrence, twist and tempering
// depends on mtg_pkg
`timescale 1ns / 1ps

module mtg_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtg_pkg::mtg_cmd_t           cmd,
    input  logic [mtg_pkg::WORD_W-1:0]  seed_value,
    output mtg_pkg::mtg_sts_t           sts,
    output logic [mtg_pkg::WORD_W-1:0]  random_word
);

    localparam int POS_W  = mtg_pkg::POS_W;
    localparam int WORD_W = mtg_pkg::WORD_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(mtg_pkg::STATE_WORDS - 1);
    localparam logic [POS_W:0]   FAR_DIST = (POS_W+1)'(mtg_pkg::SHIFT_DIST);
    localparam logic [POS_W:0]   WORDS_X  = (POS_W+1)'(mtg_pkg::STATE_WORDS);

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [WORD_W-1:0] mem [mtg_pkg::STATE_WORDS];

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  fill_idx_reg;
    logic [WORD_W-1:0] prev_reg;
    logic [WORD_W-1:0] pair_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg;

    logic [POS_W:0]    far_sum;
    logic [POS_W-1:0]  far_pos;
    logic [POS_W-1:0]  rd_a_addr;
    logic [WORD_W-1:0] seed_prod;
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] twisted;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    // neighbor addresses with wrap
    always_comb
    begin
        pos_next  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        far_sum   = {1'b0, pos_reg} + FAR_DIST;
        far_pos   = (far_sum >= WORDS_X) ? POS_W'(far_sum - WORDS_X) : far_sum[POS_W-1:0];
        rd_a_addr = cmd.read_far ? far_pos : pos_reg;
    end

    // seed recurrence: low word of the product plus the index
    always_comb
    begin
        seed_prod = mtg_pkg::SEED_MULT * (prev_reg ^ (prev_reg >> 30));
        fill_word = seed_prod + WORD_W'(fill_idx_reg);
    end

    // twist of the word at the draw position
    always_comb
    begin
        twisted = rd_a_reg ^ (pair_reg >> 1);
        if (pair_reg[0])
        begin
            twisted = twisted ^ mtg_pkg::TWIST_XOR;
        end
    end

    // write port select
    always_comb
    begin
        wr_en   = cmd.load_seed | cmd.fill_step | cmd.commit;
        wr_addr = pos_reg;
        wr_data = twisted;
        if (cmd.load_seed)
        begin
            wr_addr = '0;
            wr_data = seed_value;
        end
        else if (cmd.fill_step)
        begin
            wr_addr = fill_idx_reg;
            wr_data = fill_word;
        end
    end

    // state memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.read_pair || cmd.read_far)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.read_pair)
        begin
            rd_b_reg <= mem[pos_next];
        end
    end

    // draw position and fill counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                pos_reg      <= '0;
                fill_idx_reg <= POS_W'(1);
            end
            else
            begin
                if (cmd.commit)
                begin
                    pos_reg <= pos_next;
                end
                if (cmd.fill_step)
                begin
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            prev_reg <= seed_value;
        end
        else if (cmd.fill_step)
        begin
            prev_reg <= fill_word;
        end
        if (cmd.capture_pair)
        begin
            pair_reg <= (rd_a_reg & mtg_pkg::UPPER_MASK) | (rd_b_reg & mtg_pkg::LOWER_MASK);
        end
        if (cmd.commit)
        begin
            word_reg <= temper(twisted);
        end
        else if (cmd.load_zero)
        begin
            word_reg <= '0;
        end
    end

    assign sts.fill_done = (fill_idx_reg == LAST_POS);
    assign random_word   = word_reg;

endmodule

// ----- rtl/core/mtg_ctrl.sv -----
// controller: request decode, sequencing and output register handshake
// depends on mtg_pkg and the defines header
`timescale 1ns / 1ps
`include "mersenne_twister_generator_defines.svh"

module mtg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_type,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  mtg_pkg::mtg_sts_t  sts,
    output mtg_pkg::mtg_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEED   = 6'b000010,
        ST_READ_A = 6'b000100,
        ST_READ_B = 6'b001000,
        ST_TWIST  = 6'b010000,
        ST_ZERO   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   seeded_reg, seeded_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   req_fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid & req_ready;
    assign slot_free = ~out_valid_reg | rsp_ready;
    assign rsp_valid = out_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        seeded_next = seeded_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_type == mtg_pkg::REQ_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                        seeded_next   = 1'b1;
                        state_next    = ST_SEED;
                    end
                    else if (seeded_reg)
                    begin
                        state_next = ST_READ_A;
                    end
                    else
                    begin
                        state_next = ST_ZERO;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_A:
            begin
                cmd.read_pair = 1'b1;
                state_next    = ST_READ_B;
            end
            ST_READ_B:
            begin
                cmd.capture_pair = 1'b1;
                cmd.read_far     = 1'b1;
                state_next       = ST_TWIST;
            end
            ST_TWIST:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ZERO:
            begin
                if (slot_free)
                begin
                    cmd.load_zero = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit || cmd.load_zero)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is loaded only when the output register can take it
    `MTG_ASSERT_IMPL(a_load_slot_free, cmd.commit || cmd.load_zero, !out_valid_reg || rsp_ready)
    // the last fill step returns to idle with the generator seeded
    `MTG_ASSERT_NEXT(a_fill_end, state_reg == ST_SEED && sts.fill_done, seeded_reg && state_reg == ST_IDLE)
    // a seeded draw goes to the memory reads, an unseeded one does not
    `MTG_ASSERT_NEXT(a_draw_path, req_fire && req_type == mtg_pkg::REQ_DRAW, (state_reg == ST_READ_A) == $past(seeded_reg))

endmodule

// ----- rtl/core/mersenne_twister_generator.sv -----
// MT19937 generator, 624 words of state, one tempered 32-bit word per draw.
// A seeded draw passes from acceptance to the result register through
// ST_READ_A and ST_READ_B (memory reads for the three state words on the two
// read ports), then ST_TWIST (twist, write-back and tempering); the twist
// state waits for as long as the previous result is still unread.
// A reseed holds off new requests until every state word is written, one
// state word per cycle through the seed multiplier. Draws before the first
// reseed return zero, loaded in ST_ZERO once the output register is free.
// A new request is taken only while the controller is idle.
// depends on mtg_pkg, mtg_if, mtg_ctrl and mtg_datapath
`timescale 1ns / 1ps

module mersenne_twister_generator (
    input  logic       clk,
    input  logic       rst_n,
    mtg_req_if.sink    req,
    mtg_rsp_if.source  rsp
);

    mtg_pkg::mtg_cmd_t cmd;
    mtg_pkg::mtg_sts_t sts;

    // sequencing and handshake control
    mtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // state memory and arithmetic
    mtg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seed_value  (req.seed_value),
        .sts         (sts),
        .random_word (rsp.random_word)
    );

endmodule

// ----- tb/mersenne_twister_generator_checker.sv -----
// scoreboard for the mt19937 generator: watches both channels, predicts each draw
// and compares it with the word the block returns
// depends on mtg_pkg and mtg_if
`timescale 1ns / 1ps

module mersenne_twister_generator_checker
    import mtg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mtg_req_if   req,
    mtg_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int REPORT_LIMIT = 10;

    // predicted generator state
    logic [WORD_W-1:0] mt_words [STATE_WORDS];
    int                draw_pos;
    logic              seeded;

    // draws accepted but not yet answered, oldest first
    logic [WORD_W-1:0] expected_words [$];

    // fill the whole state from a seed with the multiply-xor recurrence
    function automatic void seed_fill(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] prev;
        mt_words[0] = seed;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            prev        = mt_words[i-1];
            mt_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
        end
        draw_pos = 0;
        seeded   = 1'b1;
    endfunction

    // twist the word at the draw position, temper it, advance
    function automatic logic [WORD_W-1:0] next_draw();
        int                pos;
        int                succ;
        int                far;
        logic [WORD_W-1:0] mixed;
        logic [WORD_W-1:0] twisted;
        logic [WORD_W-1:0] y;
        pos = (draw_pos >= STATE_WORDS) ? 0 : draw_pos;
        succ = (pos + 1 >= STATE_WORDS) ? pos + 1 - STATE_WORDS : pos + 1;
        far = (pos + SHIFT_DIST >= STATE_WORDS) ? pos + SHIFT_DIST - STATE_WORDS
                                                 : pos + SHIFT_DIST;
        mixed   = (mt_words[pos] & UPPER_MASK) | (mt_words[succ] & LOWER_MASK);
        twisted = mt_words[far] ^ (mixed >> 1);
        if (mixed[0])
            twisted = twisted ^ TWIST_XOR;
        mt_words[pos] = twisted;

        // tempering
        y = twisted;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);

        draw_pos = succ;
        return y;
    endfunction

    // sample both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            draw_pos    = 0;
            seeded      = 1'b0;
            mismatches  = 0;
            outstanding = 0;
            expected_words.delete();
        end
        else
        begin
            // request transaction
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_RESEED)
                    seed_fill(req.seed_value);
                else if (!seeded)
                    expected_words.push_back('0);
                else
                    expected_words.push_back(next_draw());
            end

            // response transaction
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected random_word %08h", $realtime,
                                 rsp.random_word);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.random_word !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: random_word expected %08h actual %08h",
                                     $realtime, want, rsp.random_word);
                    end
                end
            end

            outstanding = expected_words.size();
        end
    end

endmodule

// ----- tb/mersenne_twister_generator_test.sv -----
// testbench top of the mt19937 generator: clock, reset, request stimulus and
// response back-pressure; the checker beside the block predicts and compares
// depends on mtg_pkg, mtg_if, mersenne_twister_generator and its checker
`timescale 1ns / 1ps

module mersenne_twister_generator_test;
    import mtg_pkg::*;

    localparam int  MIXED_ITEMS  = 60;
    localparam int  WRAP_DRAWS   = 660;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 700;
    localparam time LIMIT_NS     = 5_000_000;

    logic clk;
    logic rst_n;

    // no random idling on either side while set
    logic calm;
    // asks the receiver for one long hold-off
    logic hold_request;

    int mismatches;
    int outstanding;

    mtg_req_if req_ch ();
    mtg_rsp_if rsp_ch ();

    mersenne_twister_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mersenne_twister_generator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // random gap decision for the sender
    function automatic bit sender_gap();
        return !calm && ($urandom_range(0, 99) < 25);
    endfunction

    // offer one request and wait for its transaction
    task automatic send_item(input logic kind, input logic [WORD_W-1:0] seed);
        while (sender_gap())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.seed_value <= seed;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // response back-pressure, with one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
            @(posedge clk);
        end
    end

    // reset and request stimulus
    initial
    begin
        logic [WORD_W-1:0] seed;
        calm         = 1'b0;
        hold_request = 1'b0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_DRAW;
        req_ch.seed_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draws before any reseed give zero
        send_item(REQ_DRAW, '0);
        send_item(REQ_DRAW, '1);
        send_item(REQ_DRAW, $urandom);

        // standard default seed, then extreme seeds
        send_item(REQ_RESEED, 32'd5489);
        repeat (5) send_item(REQ_DRAW, $urandom);
        send_item(REQ_RESEED, '0);
        repeat (3) send_item(REQ_DRAW, '1);
        send_item(REQ_RESEED, '1);
        repeat (3) send_item(REQ_DRAW, '0);
        send_item(REQ_RESEED, 32'd1);
        repeat (2) send_item(REQ_DRAW, $urandom);

        // back-to-back reseeds, the second one wins
        send_item(REQ_RESEED, $urandom);
        send_item(REQ_RESEED, $urandom);
        repeat (2) send_item(REQ_DRAW, $urandom);

        // mixed draws and reseeds
        for (int n = 0; n < MIXED_ITEMS; n++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       seed = '0;
                    1:       seed = '1;
                    default: seed = $urandom;
                endcase
                send_item(REQ_RESEED, seed);
            end
            else
                send_item(REQ_DRAW, $urandom);
        end

        // sender pauses until every draw has been answered
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);

        // one seed, then enough draws to wrap the draw position
        send_item(REQ_RESEED, $urandom);
        for (int n = 0; n < WRAP_DRAWS; n++)
        begin
            calm = (n >= 200 && n < 360);
            if (n == 100)
                hold_request = 1'b1;
            send_item(REQ_DRAW, $urandom);
        end
        calm = 1'b0;

        // drain and verdict
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- mersenne_twister_generator.f -----
+incdir+rtl/core
rtl/core/mtg_pkg.sv
rtl/core/mtg_if.sv
rtl/core/mtg_datapath.sv
rtl/core/mtg_ctrl.sv
rtl/core/mersenne_twister_generator.sv
tb/mersenne_twister_generator_checker.sv
tb/mersenne_twister_generator_test.sv
